// File: sv/lhp_pkg.sv
// shared constants, datapath command codes and status struct for the latency histogram
package lhp_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 1024;
  localparam logic [31:0] MAX_LAT_RESET   = 32'd1000000;
  localparam int unsigned BP_SCALE        = 10000;
  localparam logic [31:0] COUNT_LIMIT     = 32'hFFFF_FFFF;

  // numerator and denominator of the interpolation stay below 10000 * 2^32
  localparam int unsigned NUM_W  = 46;
  localparam int unsigned DEN_W  = 46;
  localparam int unsigned HALF_W = 23;
  localparam int unsigned DIV_W  = 78;
  localparam int unsigned Q_W    = 32;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_MULT_LAT,
    DP_BKT_LAST,
    DP_DIV_BKT,
    DP_BKT_Q,
    DP_RD_BKT,
    DP_WR_INC,
    DP_TARGET,
    DP_SCAN_RD,
    DP_SCAN_MUL,
    DP_SCAN_HIT,
    DP_SCAN_NEXT,
    DP_RCP_LO,
    DP_RCP_HI,
    DP_SIZE_LATCH,
    DP_REM,
    DP_MUL_START,
    DP_START_LATCH,
    DP_PP_LO,
    DP_PP_HI,
    DP_DIV_Q,
    DP_OUT_VAL,
    DP_OUT_EMPTY,
    DP_OUT_BEYOND
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic lat_ge_max;
    logic total_zero;
    logic scan_hit;
    logic idx_last;
  } dp_status_t;

endpackage

// File: sv/latency_histogram_percentile.sv
// latency histogram with linear buckets and percentile query, top level
// record: bucket index by division (last bucket at or above max latency), then read and increment
// clear: one memory row written per cycle
// query: target, then read, multiply and compare per bucket scanned, interpolation, divide, then the result strobe
// reset clears the memory in a pass over all buckets with busy high
// results are one-cycle strobes; the receiver cannot stall them
module latency_histogram_percentile import lhp_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_latency_ns,
  input  logic [13:0] in_percentile_bp,
  output logic        out_valid,
  output logic [31:0] out_percentile_value,
  output logic        out_histogram_empty,
  output logic        out_beyond_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lhp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  lhp_datapath #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_latency_ns       (in_latency_ns),
    .in_percentile_bp    (in_percentile_bp),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_percentile_value(out_percentile_value),
    .out_histogram_empty (out_histogram_empty),
    .out_beyond_range    (out_beyond_range)
  );

endmodule

// File: sv/lhp_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
module lhp_div import lhp_pkg::*; #(
  parameter int unsigned SHORT_STEPS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             short_run,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [Q_W-1:0]   quotient
);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] ds_r;
  logic [Q_W-1:0]   quo_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic [DIV_W-1:0] dz;

  assign dz = {{(DIV_W-DEN_W){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      rem_r  <= dividend;
      quo_r  <= '0;
      busy_r <= 1'b1;
      if (short_run) begin
        ds_r  <= dz << (SHORT_STEPS - 1);
        cnt_r <= 5'(SHORT_STEPS - 1);
      end else begin
        ds_r  <= dz << (Q_W - 1);
        cnt_r <= 5'(Q_W - 1);
      end
    end else if (busy_r) begin
      if (rem_r >= ds_r) begin
        rem_r <= rem_r - ds_r;
        quo_r <= {quo_r[Q_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[Q_W-2:0], 1'b0};
      end
      ds_r <= ds_r >> 1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: sv/lhp_datapath.sv
// bucket memory, totals, scan registers, multipliers and result registers
module lhp_datapath import lhp_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [31:0] in_latency_ns,
  input  logic [13:0] in_percentile_bp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_percentile_value,
  output logic        out_histogram_empty,
  output logic        out_beyond_range
);

  localparam int unsigned IW  = $clog2(NUM_BUCKETS);
  localparam int unsigned TW  = 32 + IW;
  localparam int unsigned TGW = TW + 14;
  localparam logic [IW-1:0]    IDX_END = IW'(NUM_BUCKETS - 1);
  // floor(x / buckets) = (x * RCP) >> RS for any 32-bit x
  localparam int unsigned      RS  = 32 + IW;
  localparam logic [32:0]      RCP =
    33'(((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  logic [31:0]      mem [NUM_BUCKETS];
  logic [31:0]      rdata_r;
  logic [31:0]      max_r;
  logic [31:0]      lat_r;
  logic [13:0]      bp_r;
  logic [TW-1:0]    total_r;
  logic [TGW-1:0]   target_r;
  logic [TGW-1:0]   cum_r;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    bkt_r;
  logic [31:0]      c_r;
  logic [DEN_W-1:0] c10k_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [31:0]      size_r;
  logic [IW-1:0]    rem_r;
  logic [31:0]      rx_r;
  logic [31:0]      start_r;
  logic [DIV_W-1:0] prod_r;
  logic             out_valid_r;
  logic [31:0]      out_value_r;
  logic             out_empty_r;
  logic             out_beyond_r;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;

  logic             div_start;
  logic             div_short;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_busy;
  logic [Q_W-1:0]   div_quo;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bkt_r;
    mem_wdata = rdata_r + 32'd1;
    if (cmd == DP_CLR_STEP) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = '0;
    end else if (cmd == DP_WR_INC && rdata_r != COUNT_LIMIT) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = (cmd == DP_RD_BKT) || (cmd == DP_SCAN_RD);
  assign mem_raddr = (cmd == DP_SCAN_RD) ? idx_r : bkt_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_short    = 1'b0;
    div_dividend = prod_r;
    div_divisor  = den_r;
    case (cmd)
      DP_DIV_BKT: begin
        div_start   = 1'b1;
        div_short   = 1'b1;
        div_divisor = DEN_W'(max_r);
      end
      DP_DIV_Q: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lhp_div #(
    .SHORT_STEPS(IW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .short_run(div_short),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_LAT_RESET;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      case (cmd)
        DP_LOAD: begin
          lat_r <= in_latency_ns;
          bp_r  <= in_percentile_bp;
          idx_r <= '0;
        end
        DP_CLR_STEP: begin
          idx_r   <= idx_r + IW'(1);
          total_r <= '0;
        end
        DP_MULT_LAT: prod_r <= DIV_W'(lat_r) * DIV_W'(NUM_BUCKETS);
        DP_BKT_LAST: bkt_r <= IDX_END;
        DP_BKT_Q:    bkt_r <= div_quo[IW-1:0];
        DP_WR_INC: begin
          if (rdata_r != COUNT_LIMIT) begin
            total_r <= total_r + TW'(1);
          end
        end
        DP_TARGET: begin
          target_r <= TGW'(total_r) * TGW'(bp_r);
          cum_r    <= '0;
          idx_r    <= '0;
        end
        DP_SCAN_MUL: begin
          c_r    <= rdata_r;
          c10k_r <= DEN_W'(rdata_r) * DEN_W'(BP_SCALE);
        end
        DP_SCAN_HIT: begin
          num_r <= NUM_W'(target_r - cum_r);
          den_r <= (c_r == 32'd0) ? DEN_W'(BP_SCALE) : c10k_r;
          rx_r  <= max_r;
        end
        DP_SCAN_NEXT: begin
          cum_r <= cum_r + TGW'(c10k_r);
          idx_r <= idx_r + IW'(1);
        end
        DP_RCP_LO: prod_r <= DIV_W'(rx_r[15:0]) * DIV_W'(RCP);
        DP_RCP_HI: begin
          prod_r <= prod_r + ((DIV_W'(rx_r[31:16]) * DIV_W'(RCP)) << 16);
        end
        DP_SIZE_LATCH: size_r <= 32'(prod_r >> RS);
        // idx*max/N = idx*size + idx*rem/N, with idx*rem below 2^32
        DP_REM: begin
          rem_r   <= IW'(max_r - 32'(48'(size_r) * 48'(NUM_BUCKETS)));
          start_r <= 32'(48'(idx_r) * 48'(size_r));
        end
        DP_MUL_START:   rx_r <= 32'(32'(idx_r) * 32'(rem_r));
        DP_START_LATCH: start_r <= start_r + 32'(prod_r >> RS);
        DP_PP_LO: prod_r <= DIV_W'(num_r[HALF_W-1:0]) * DIV_W'(size_r);
        DP_PP_HI: begin
          prod_r <= prod_r + ((DIV_W'(num_r[NUM_W-1:HALF_W]) * DIV_W'(size_r)) << HALF_W);
        end
        DP_OUT_VAL: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= start_r + div_quo;
          out_empty_r  <= 1'b0;
          out_beyond_r <= 1'b0;
        end
        DP_OUT_EMPTY: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= '0;
          out_empty_r  <= 1'b1;
          out_beyond_r <= 1'b0;
        end
        DP_OUT_BEYOND: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= max_r;
          out_empty_r  <= 1'b0;
          out_beyond_r <= 1'b1;
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign status.div_busy   = div_busy;
  assign status.lat_ge_max = (lat_r >= max_r);
  assign status.total_zero = (total_r == '0);
  assign status.scan_hit   = ((cum_r + TGW'(c10k_r)) >= target_r);
  assign status.idx_last   = (idx_r == IDX_END);

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_value_r;
  assign out_histogram_empty  = out_empty_r;
  assign out_beyond_range     = out_beyond_r;

endmodule

// File: sv/lhp_ctrl.sv
// controller that sequences record, clear and percentile query requests
module lhp_ctrl import lhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_REC_MUL,
    S_REC_DIV,
    S_REC_WAIT,
    S_REC_RD,
    S_REC_WR,
    S_Q_TGT,
    S_Q_RD,
    S_Q_MUL,
    S_Q_CMP,
    S_Q_SLO,
    S_Q_SHI,
    S_Q_SLAT,
    S_Q_REM,
    S_Q_MST,
    S_Q_TLO,
    S_Q_THI,
    S_Q_STL,
    S_Q_PLO,
    S_Q_PHI,
    S_Q_DQ,
    S_Q_DQW
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = DP_LOAD;
          case (in_operation)
            OP_RECORD: state_nxt = S_REC_MUL;
            OP_QUERY:  state_nxt = S_Q_TGT;
            OP_CLEAR:  state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd = DP_CLR_STEP;
        if (status.idx_last) state_nxt = S_IDLE;
      end
      S_REC_MUL: begin
        cmd       = DP_MULT_LAT;
        state_nxt = S_REC_DIV;
      end
      S_REC_DIV: begin
        if (status.lat_ge_max) begin
          cmd       = DP_BKT_LAST;
          state_nxt = S_REC_RD;
        end else begin
          cmd       = DP_DIV_BKT;
          state_nxt = S_REC_WAIT;
        end
      end
      S_REC_WAIT: begin
        if (!status.div_busy) begin
          cmd       = DP_BKT_Q;
          state_nxt = S_REC_RD;
        end
      end
      S_REC_RD: begin
        cmd       = DP_RD_BKT;
        state_nxt = S_REC_WR;
      end
      S_REC_WR: begin
        cmd       = DP_WR_INC;
        state_nxt = S_IDLE;
      end
      S_Q_TGT: begin
        if (status.total_zero) begin
          cmd       = DP_OUT_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd       = DP_TARGET;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        cmd       = DP_SCAN_RD;
        state_nxt = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd       = DP_SCAN_MUL;
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (status.scan_hit) begin
          cmd       = DP_SCAN_HIT;
          state_nxt = S_Q_SLO;
        end else if (status.idx_last) begin
          cmd       = DP_OUT_BEYOND;
          state_nxt = S_IDLE;
        end else begin
          cmd       = DP_SCAN_NEXT;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_SLO: begin
        cmd       = DP_RCP_LO;
        state_nxt = S_Q_SHI;
      end
      S_Q_SHI: begin
        cmd       = DP_RCP_HI;
        state_nxt = S_Q_SLAT;
      end
      S_Q_SLAT: begin
        cmd       = DP_SIZE_LATCH;
        state_nxt = S_Q_REM;
      end
      S_Q_REM: begin
        cmd       = DP_REM;
        state_nxt = S_Q_MST;
      end
      S_Q_MST: begin
        cmd       = DP_MUL_START;
        state_nxt = S_Q_TLO;
      end
      S_Q_TLO: begin
        cmd       = DP_RCP_LO;
        state_nxt = S_Q_THI;
      end
      S_Q_THI: begin
        cmd       = DP_RCP_HI;
        state_nxt = S_Q_STL;
      end
      S_Q_STL: begin
        cmd       = DP_START_LATCH;
        state_nxt = S_Q_PLO;
      end
      S_Q_PLO: begin
        cmd       = DP_PP_LO;
        state_nxt = S_Q_PHI;
      end
      S_Q_PHI: begin
        cmd       = DP_PP_HI;
        state_nxt = S_Q_DQ;
      end
      S_Q_DQ: begin
        cmd       = DP_DIV_Q;
        state_nxt = S_Q_DQW;
      end
      S_Q_DQW: begin
        if (!status.div_busy) begin
          cmd       = DP_OUT_VAL;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reset starts with a pass that zeroes the bucket memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: sv/lhp_checker.sv
// port level checks for the latency histogram, bound to the top level
module lhp_checker import lhp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic [31:0] out_percentile_value,
  input logic        out_histogram_empty,
  input logic        out_beyond_range
);

  // every query passes through states of work before its result, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_histogram_empty) |-> (out_percentile_value == 32'd0))
    else $error("empty histogram result with nonzero value");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_histogram_empty && out_beyond_range))
    else $error("empty and beyond range both set");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_RECORD || in_operation == OP_CLEAR)) |=> busy)
    else $error("record or clear request did not raise busy");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(!busy) && $past(!start)) |-> !out_valid)
    else $error("result strobe without a request");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_operation        (in_operation),
  .out_valid           (out_valid),
  .out_percentile_value(out_percentile_value),
  .out_histogram_empty (out_histogram_empty),
  .out_beyond_range    (out_beyond_range)
);
